FILE: hdl/qrv_pkg.sv
// Quaternion vector rotation: shared widths and the word passed from the
// front end to the divider back end. No dependencies.
package qrv_pkg;

    localparam int QUAT_W = 16;               // Q2.14 quaternion component
    localparam int VEC_W  = 32;               // Q16.16 vector component
    localparam int SQ_W   = 2 * QUAT_W;       // product of two components
    localparam int MAT_W  = SQ_W + 2;         // rotation matrix entry
    localparam int NORM_W = SQ_W + 1;         // squared norm, unsigned
    localparam int PROD_W = MAT_W + VEC_W;    // matrix entry times vector
    localparam int NUM_W  = PROD_W + 2;       // sum of three products
    localparam int QUO_W  = 33;               // quotient magnitude bits
    localparam int DIV_W  = NUM_W + 2;        // 2*|num| + norm
    localparam int REM_W  = NORM_W + 1;       // divisor 2*norm
    localparam int LANES  = 3;

    localparam logic [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
    localparam logic [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

    typedef struct packed {
        logic signed [NUM_W-1:0] num_x;
        logic signed [NUM_W-1:0] num_y;
        logic signed [NUM_W-1:0] num_z;
        logic [NORM_W-1:0]       norm;
        logic                    degenerate;
    } work_t;

endpackage

FILE: hdl/qrv_if.sv
// Quaternion vector rotation: input and result channel interfaces.
// Depends on qrv_pkg.
interface qrv_in_if;
    import qrv_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [VEC_W-1:0]  vec_x;
    logic signed [VEC_W-1:0]  vec_y;
    logic signed [VEC_W-1:0]  vec_z;
    modport source (output valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
                    input ready);
    modport sink (input valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
                  output ready);
endinterface

interface qrv_out_if;
    import qrv_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VEC_W-1:0] rot_x;
    logic signed [VEC_W-1:0] rot_y;
    logic signed [VEC_W-1:0] rot_z;
    logic                    degenerate;
    logic                    saturated;
    modport source (output valid, rot_x, rot_y, rot_z, degenerate, saturated, input ready);
    modport sink (input valid, rot_x, rot_y, rot_z, degenerate, saturated, output ready);
endinterface

FILE: hdl/quaternion_rotate_vector_unit.sv
// Quaternion vector rotation unit: rotates a Q16.16 vector by a Q2.14 quaternion.
// Stages from input word to result word: 4 front stages, the queue, 1 setup,
// 33 divide stages, 1 output register. Throughput: one word per cycle while
// results are taken; the 33-stage bit-per-stage divider sets depth.
// Reset (rst_n, async, active low) empties all stages and the queue; no other state.
// Depends on qrv_pkg, qrv_if, qrv_front, qrv_fifo, qrv_divider.
module quaternion_rotate_vector_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    qrv_in_if.sink    item,
    qrv_out_if.source result
);
    import qrv_pkg::*;

    // front end -> queue
    logic  fr_valid, fr_ready;
    work_t fr_word;
    // queue -> divider
    logic  bk_valid, bk_ready;
    work_t bk_word;

    // Front end: forms M*v exactly for all three rows plus the squared norm,
    // and marks a zero quaternion. It stalls only when the queue is full.
    qrv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .work_valid (fr_valid),
        .work_ready (fr_ready),
        .work       (fr_word)
    );

    // Queue decouples the front end from the divider so either side can hold.
    qrv_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_word  (fr_word),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_word   (bk_word)
    );

    // Back end: divides each numerator once by the norm with round half away
    // from zero, then clamps to Q16.16. The output register holds a result
    // word until it is taken; the divider stages behind it stall meanwhile.
    qrv_divider u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (bk_valid),
        .work_ready (bk_ready),
        .work       (bk_word),
        .result     (result)
    );

`ifndef SYNTHESIS
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.degenerate) |->
        (result.rot_x == '0 && result.rot_y == '0 && result.rot_z == '0))
        else $error("degenerate result not zero");
    a_deg_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.degenerate) |-> !result.saturated)
        else $error("degenerate result flagged saturated");
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.saturated) |->
        (result.rot_x == VEC_MAX || result.rot_x == VEC_MIN ||
         result.rot_y == VEC_MAX || result.rot_y == VEC_MIN ||
         result.rot_z == VEC_MAX || result.rot_z == VEC_MIN))
        else $error("saturated flag without a clamped component");
`endif

endmodule

FILE: hdl/qrv_front.sv
// Quaternion vector rotation front end: products, matrix, norm and the
// three exact numerators, four stages. Depends on qrv_pkg, qrv_if.
module qrv_front (
    input  logic             clk,
    input  logic             rst_n,
    qrv_in_if.sink           item,
    output logic             work_valid,
    input  logic             work_ready,
    output qrv_pkg::work_t   work
);
    import qrv_pkg::*;

    logic [3:0] vld_reg;
    logic       adv;

    logic signed [SQ_W-1:0]   xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [SQ_W-1:0]   xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [VEC_W-1:0]  v1_reg [LANES];
    logic signed [VEC_W-1:0]  v2_reg [LANES];
    logic signed [MAT_W-1:0]  m2_reg [9];
    logic [NORM_W-1:0]        n2_reg, n3_reg;
    logic signed [PROD_W-1:0] p3_reg [9];
    work_t                    w4_reg;

    // advance the whole front end unless the last word cannot leave
    assign adv        = !vld_reg[3] || work_ready;
    assign item.ready = adv;
    assign work_valid = vld_reg[3];
    assign work       = w4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[2:0], item.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xx_reg <= item.quat_x * item.quat_x;
            yy_reg <= item.quat_y * item.quat_y;
            zz_reg <= item.quat_z * item.quat_z;
            ww_reg <= item.quat_w * item.quat_w;
            xy_reg <= item.quat_x * item.quat_y;
            xz_reg <= item.quat_x * item.quat_z;
            yz_reg <= item.quat_y * item.quat_z;
            wx_reg <= item.quat_w * item.quat_x;
            wy_reg <= item.quat_w * item.quat_y;
            wz_reg <= item.quat_w * item.quat_z;
            v1_reg[0] <= item.vec_x;
            v1_reg[1] <= item.vec_y;
            v1_reg[2] <= item.vec_z;

            m2_reg[0] <= MAT_W'(ww_reg) + MAT_W'(xx_reg) - MAT_W'(yy_reg) - MAT_W'(zz_reg);
            m2_reg[1] <= (MAT_W'(xy_reg) - MAT_W'(wz_reg)) <<< 1;
            m2_reg[2] <= (MAT_W'(xz_reg) + MAT_W'(wy_reg)) <<< 1;
            m2_reg[3] <= (MAT_W'(xy_reg) + MAT_W'(wz_reg)) <<< 1;
            m2_reg[4] <= MAT_W'(ww_reg) - MAT_W'(xx_reg) + MAT_W'(yy_reg) - MAT_W'(zz_reg);
            m2_reg[5] <= (MAT_W'(yz_reg) - MAT_W'(wx_reg)) <<< 1;
            m2_reg[6] <= (MAT_W'(xz_reg) - MAT_W'(wy_reg)) <<< 1;
            m2_reg[7] <= (MAT_W'(yz_reg) + MAT_W'(wx_reg)) <<< 1;
            m2_reg[8] <= MAT_W'(ww_reg) - MAT_W'(xx_reg) - MAT_W'(yy_reg) + MAT_W'(zz_reg);
            n2_reg    <= NORM_W'(xx_reg) + NORM_W'(yy_reg) + NORM_W'(zz_reg)
                       + NORM_W'(ww_reg);
            for (int l = 0; l < LANES; l++)
            begin
                v2_reg[l] <= v1_reg[l];
            end

            for (int i = 0; i < 9; i++)
            begin
                p3_reg[i] <= m2_reg[i] * v2_reg[i % 3];
            end
            n3_reg <= n2_reg;

            w4_reg.num_x      <= NUM_W'(p3_reg[0]) + NUM_W'(p3_reg[1]) + NUM_W'(p3_reg[2]);
            w4_reg.num_y      <= NUM_W'(p3_reg[3]) + NUM_W'(p3_reg[4]) + NUM_W'(p3_reg[5]);
            w4_reg.num_z      <= NUM_W'(p3_reg[6]) + NUM_W'(p3_reg[7]) + NUM_W'(p3_reg[8]);
            w4_reg.norm       <= n3_reg;
            w4_reg.degenerate <= (n3_reg == '0);
        end
    end

endmodule

FILE: hdl/qrv_fifo.sv
// Quaternion vector rotation: short word queue between front end and
// divider. Depends on qrv_pkg.
module qrv_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  qrv_pkg::work_t push_word,
    output logic           pop_valid,
    input  logic           pop_ready,
    output qrv_pkg::work_t pop_word
);
    import qrv_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    work_t           mem_reg [DEPTH];
    logic [PW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   cnt_reg;
    logic            push, pop;

    assign push_ready = (cnt_reg != CW'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_word   = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == LAST) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == LAST) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_word;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH)) else $error("queue count beyond depth");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wr_reg == rd_reg)) else $error("empty queue, pointers differ");
    a_full_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == CW'(DEPTH)) |-> (wr_reg == rd_reg)) else $error("full queue, pointers differ");
`endif

endmodule

FILE: hdl/qrv_divider.sv
// Quaternion vector rotation back end: rounding setup, pipelined restoring
// divide one quotient bit per stage, sign and clamp. Depends on qrv_pkg, qrv_if.
module qrv_divider (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           work_valid,
    output logic           work_ready,
    input  qrv_pkg::work_t work,
    qrv_out_if.source      result
);
    import qrv_pkg::*;

    logic                     adv;
    logic                     res_valid_reg;
    logic [QUO_W:0]           vld_reg;
    logic [REM_W-1:0]         r_reg   [QUO_W+1][LANES];
    logic [QUO_W-1:0]         dl_reg  [QUO_W+1][LANES];
    logic [QUO_W-1:0]         q_reg   [QUO_W+1][LANES];
    logic                     neg_reg [QUO_W+1][LANES];
    logic [REM_W-1:0]         d_reg   [QUO_W+1];
    logic                     deg_reg [QUO_W+1];
    logic signed [NUM_W-1:0]  num     [LANES];
    logic [NUM_W-1:0]         mag     [LANES];
    logic [DIV_W-1:0]         dvd     [LANES];
    logic [VEC_W-1:0]         rot_next [LANES];
    logic [LANES-1:0]         clamp;
    logic [VEC_W-1:0]         rot_reg [LANES];
    logic                     deg_out_reg, sat_out_reg;

    // stall every stage together while a result word waits
    assign adv        = !res_valid_reg || result.ready;
    assign work_ready = adv;

    assign num[0] = work.num_x;
    assign num[1] = work.num_y;
    assign num[2] = work.num_z;

    // round half away: floor((2|a| + n) / 2n)
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            mag[l] = num[l][NUM_W-1] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
            dvd[l] = DIV_W'({mag[l], 1'b0}) + DIV_W'(work.norm);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= work_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                r_reg[0][l]   <= dvd[l][QUO_W +: REM_W];
                dl_reg[0][l]  <= dvd[l][QUO_W-1:0];
                q_reg[0][l]   <= '0;
                neg_reg[0][l] <= num[l][NUM_W-1];
            end
            d_reg[0]   <= {work.norm, 1'b0};
            deg_reg[0] <= work.degenerate;
        end
    end

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        logic [REM_W:0]   rs [LANES];
        logic [REM_W-1:0] rn [LANES];
        logic             qb [LANES];

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rs[l] = {r_reg[s][l], dl_reg[s][l][QUO_W-1]};
                if (rs[l] >= {1'b0, d_reg[s]})
                begin
                    rn[l] = REM_W'(rs[l] - {1'b0, d_reg[s]});
                    qb[l] = 1'b1;
                end
                else
                begin
                    rn[l] = rs[l][REM_W-1:0];
                    qb[l] = 1'b0;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    r_reg[s+1][l]   <= rn[l];
                    dl_reg[s+1][l]  <= dl_reg[s][l] << 1;
                    q_reg[s+1][l]   <= {q_reg[s][l][QUO_W-2:0], qb[l]};
                    neg_reg[s+1][l] <= neg_reg[s][l];
                end
                d_reg[s+1]   <= d_reg[s];
                deg_reg[s+1] <= deg_reg[s];
            end
        end
    end

    // apply sign, clamp to Q16.16
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (neg_reg[QUO_W][l])
            begin
                clamp[l] = q_reg[QUO_W][l][QUO_W-1]
                        || (q_reg[QUO_W][l][VEC_W-1] && (q_reg[QUO_W][l][VEC_W-2:0] != '0));
                rot_next[l] = clamp[l] ? VEC_MIN : VEC_W'(-q_reg[QUO_W][l][VEC_W-1:0]);
            end
            else
            begin
                clamp[l]    = (q_reg[QUO_W][l][QUO_W-1:VEC_W-1] != '0);
                rot_next[l] = clamp[l] ? VEC_MAX : q_reg[QUO_W][l][VEC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= vld_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rot_reg[l] <= deg_reg[QUO_W] ? '0 : rot_next[l];
            end
            deg_out_reg <= deg_reg[QUO_W];
            sat_out_reg <= !deg_reg[QUO_W] && (clamp != '0);
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.rot_x      = rot_reg[0];
    assign result.rot_y      = rot_reg[1];
    assign result.rot_z      = rot_reg[2];
    assign result.degenerate = deg_out_reg;
    assign result.saturated  = sat_out_reg;

endmodule

FILE: tb/sv/tb_quaternion_rotate_vector_unit.sv
`timescale 1ns / 100ps
// Testbench for quaternion_rotate_vector_unit: drives quaternion/vector words,
// predicts each rotated vector in fixed point and checks the result stream.
// Depends on qrv_pkg, qrv_if and the unit itself.
module tb_quaternion_rotate_vector_unit;
    import qrv_pkg::*;

    localparam int LATENCY     = 40;
    localparam int N_RANDOM    = 1030;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic signed [VEC_W-1:0] rot_x;
        logic signed [VEC_W-1:0] rot_y;
        logic signed [VEC_W-1:0] rot_z;
        logic                    degenerate;
        logic                    saturated;
    } rotation_t;

    typedef struct {
        logic signed [QUAT_W-1:0] q[4];   // x, y, z, w
        logic signed [VEC_W-1:0]  v[3];
        bit                       typed;  // expected result given in the row
        rotation_t                res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycle_count = 0;
    bit   failed = 1'b0;
    bit   in_done = 1'b0;
    bit   hold_off = 1'b0;  // long receiver stall request
    bit   no_idle = 1'b0;   // stretch with no random idling

    qrv_in_if  item();
    qrv_out_if result();

    quaternion_rotate_vector_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item.sink),
        .result(result.source)
    );

    rotation_t expected_rotations[$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Round (num / norm) to nearest, ties away from zero, then clamp to 32 bits.
    function automatic logic signed [VEC_W-1:0] round_clamp(input logic signed [127:0] num,
                                                              input logic signed [127:0] norm,
                                                              inout bit sat);
        logic signed [127:0] mag;
        logic signed [127:0] quo;
        logic signed [127:0] rem;
        mag = (num < 0) ? -num : num;
        quo = mag / norm;
        rem = mag % norm;
        if (2 * rem >= norm)
            quo = quo + 1;
        if (num < 0)
            quo = -quo;
        if (quo > 128'sd2147483647)
        begin
            sat = 1'b1;
            return VEC_MAX;
        end
        if (quo < -128'sd2147483648)
        begin
            sat = 1'b1;
            return VEC_MIN;
        end
        return quo[VEC_W-1:0];
    endfunction

    // Vector part of q * (v,0) * conj(q) / |q|^2 at full width.
    function automatic rotation_t rotate_vector(input logic signed [QUAT_W-1:0] q[4],
                                                input logic signed [VEC_W-1:0] v[3]);
        logic signed [127:0] x, y, z, w, norm;
        logic signed [127:0] m[3][3];
        logic signed [127:0] acc;
        logic signed [VEC_W-1:0] r[3];
        rotation_t rot;
        bit sat;
        x = 128'(q[0]); y = 128'(q[1]); z = 128'(q[2]); w = 128'(q[3]);
        sat = 1'b0;
        norm = x * x + y * y + z * z + w * w;
        rot = '0;
        if (norm == 0)
        begin
            rot.degenerate = 1'b1;
            return rot;
        end
        m[0][0] = w * w + x * x - y * y - z * z;
        m[0][1] = 2 * (x * y - w * z);
        m[0][2] = 2 * (x * z + w * y);
        m[1][0] = 2 * (x * y + w * z);
        m[1][1] = w * w - x * x + y * y - z * z;
        m[1][2] = 2 * (y * z - w * x);
        m[2][0] = 2 * (x * z - w * y);
        m[2][1] = 2 * (y * z + w * x);
        m[2][2] = w * w - x * x - y * y + z * z;
        for (int i = 0; i < 3; i++)
        begin
            acc = '0;
            for (int k = 0; k < 3; k++)
                acc = acc + m[i][k] * 128'(signed'(v[k]));
            r[i] = round_clamp(acc, norm, sat);
        end
        rot.rot_x = r[0];
        rot.rot_y = r[1];
        rot.rot_z = r[2];
        rot.saturated = sat;
        return rot;
    endfunction

    function automatic stim_row_t make_row(input int qx, qy, qz, qw,
                                           input int vx, vy, vz);
        stim_row_t row;
        row.q[0] = QUAT_W'(qx); row.q[1] = QUAT_W'(qy);
        row.q[2] = QUAT_W'(qz); row.q[3] = QUAT_W'(qw);
        row.v[0] = vx; row.v[1] = vy; row.v[2] = vz;
        row.typed = 1'b0;
        row.res = '0;
        return row;
    endfunction

    function automatic stim_row_t make_typed(input stim_row_t row, input rotation_t res);
        row.typed = 1'b1;
        row.res = res;
        return row;
    endfunction

    // Directed stimulus table.
    stim_row_t directed[$];

    initial
    begin
        // zero quaternion: zero vector, degenerate set
        directed.push_back(make_typed(make_row(0, 0, 0, 0, 32'h7FFFFFFF, -5, 123),
                                      '{0, 0, 0, 1'b1, 1'b0}));
        // identity rotation returns the vector unchanged
        directed.push_back(make_typed(make_row(0, 0, 0, 16384, 65536, -65536, 7),
                                      '{65536, -65536, 7, 1'b0, 1'b0}));
        directed.push_back(make_typed(make_row(0, 0, 0, -32768,
                                               32'h7FFFFFFF, 32'h80000000, 0),
                                      '{32'h7FFFFFFF, 32'h80000000, 0, 1'b0, 1'b0}));
        // 180 degrees about x flips y and z; -MIN saturates
        directed.push_back(make_typed(make_row(16384, 0, 0, 0, 1, 32'h80000000, 2),
                                      '{1, 32'h7FFFFFFF, -2, 1'b0, 1'b1}));
        // extremes of every field
        directed.push_back(make_row(32767, 32767, 32767, 32767,
                                    32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        directed.push_back(make_row(-32768, -32768, -32768, -32768,
                                    32'h80000000, 32'h80000000, 32'h80000000));
        directed.push_back(make_row(-32768, 32767, -1, 1, 32'h80000000, 32'h7FFFFFFF, -1));
        directed.push_back(make_row(1, 0, 0, 0, 3, 5, 7));
        directed.push_back(make_row(0, 1, 0, 0, -3, 5, -7));
        directed.push_back(make_row(0, 0, 1, 0, 1, 1, 1));
        directed.push_back(make_row(0, 0, 0, 1, -1, -1, -1));
        // non-unit norm, rounding ties and remainders
        directed.push_back(make_row(1, 1, 0, 0, 1, 0, 0));
        directed.push_back(make_row(1, 1, 1, 1, 3, 1, 1));
        directed.push_back(make_row(0, 0, 3, 4, 1, 2, 3));
        directed.push_back(make_row(0, 0, -3, 4, -1, -2, -3));
        directed.push_back(make_row(1, 2, 3, 4, 32'h7FFFFFFF, 0, 32'h80000000));
        // tiny norm with big vector saturates
        directed.push_back(make_row(1, 0, 0, 1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000));
        directed.push_back(make_row(11585, 0, 0, 11585, 65536, 65536, 65536));
        directed.push_back(make_row(0, 11585, 0, 11585, 65536, -65536, 65536));
    end

    // Drive one word at the falling edge, hold it until accepted.
    task automatic send_word(input stim_row_t row);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 7)
            @(negedge clk);
        item.quat_x <= row.q[0];
        item.quat_y <= row.q[1];
        item.quat_z <= row.q[2];
        item.quat_w <= row.q[3];
        item.vec_x  <= row.v[0];
        item.vec_y  <= row.v[1];
        item.vec_z  <= row.v[2];
        item.valid  <= 1'b1;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        if (row.typed)
            expected_rotations.push_back(row.res);
        else
            expected_rotations.push_back(rotate_vector(row.q, row.v));
        item.valid <= 1'b0;
    endtask

    function automatic logic signed [QUAT_W-1:0] rand_quat();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return QUAT_W'($urandom_range(7) - 4);
            default: return QUAT_W'($urandom());
        endcase
    endfunction

    function automatic logic signed [VEC_W-1:0] rand_vec();
        case ($urandom_range(5))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return $urandom_range(65535) - 32768;
            default: return $urandom();
        endcase
    endfunction

    // Sender
    initial
    begin
        stim_row_t row;
        item.valid  = 1'b0;
        item.quat_x = '0; item.quat_y = '0; item.quat_z = '0; item.quat_w = '0;
        item.vec_x  = '0; item.vec_y  = '0; item.vec_z  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (directed[i])
            send_word(directed[i]);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            // burst with no idling, then one long receiver stall
            no_idle = (n >= 200 && n < 400);
            hold_off = (n >= 500 && n < 510);
            row = make_row(0, 0, 0, 0, 0, 0, 0);
            for (int k = 0; k < 4; k++)
                row.q[k] = rand_quat();
            if ($urandom_range(49) == 0)
                row.q = '{0, 0, 0, 0};
            for (int k = 0; k < 3; k++)
                row.v[k] = rand_vec();
            send_word(row);
        end
        no_idle = 1'b0;
        hold_off = 1'b0;
        in_done = 1'b1;
    end

    // Receiver: random idling and one long hold-off counted here.
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        result.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off && stall_cycles == 0)
                stall_cycles = 150;
            if (stall_cycles > 1)
            begin
                stall_cycles--;
                result.ready <= 1'b0;
            end
            else
            begin
                if (stall_cycles == 1)
                    hold_off = 1'b0;
                stall_cycles = (stall_cycles == 1) ? -1 : stall_cycles;
                result.ready <= no_idle || ($urandom_range(99) >= 7);
            end
        end
    end

    // Checker: compare each accepted word with the oldest expectation.
    always @(posedge clk)
    begin
        rotation_t got;
        rotation_t exp_rot;
        if (rst_n && result.valid && result.ready)
        begin
            got = '{result.rot_x, result.rot_y, result.rot_z,
                    result.degenerate, result.saturated};
            if (expected_rotations.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, got);
                failed = 1'b1;
            end
            else
            begin
                exp_rot = expected_rotations.pop_front();
                if (got !== exp_rot)
                begin
                    $display("%0t: mismatch expected x=%0d y=%0d z=%0d deg=%b sat=%b",
                             $time, exp_rot.rot_x, exp_rot.rot_y, exp_rot.rot_z,
                             exp_rot.degenerate, exp_rot.saturated);
                    $display("%0t:          actual   x=%0d y=%0d z=%0d deg=%b sat=%b",
                             $time, got.rot_x, got.rot_y, got.rot_z,
                             got.degenerate, got.saturated);
                    failed = 1'b1;
                end
            end
        end
    end

    // Finish once all words are in and every result has drained.
    initial
    begin
        wait (in_done);
        wait (expected_rotations.size() == 0);
        repeat (LATENCY * 2) @(posedge clk);
        if (!failed && expected_rotations.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/qrv_pkg.sv
hdl/qrv_if.sv
hdl/qrv_front.sv
hdl/qrv_fifo.sv
hdl/qrv_divider.sv
hdl/quaternion_rotate_vector_unit.sv
tb/sv/tb_quaternion_rotate_vector_unit.sv
